[rtl/core/triangle_area_and_normal_defines.svh]
// Assertion macros for the triangle area and normal top level.
`ifndef TRIANGLE_AREA_AND_NORMAL_DEFINES_SVH
`define TRIANGLE_AREA_AND_NORMAL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TAN_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TAN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tan_pkg.sv]
// Shared constants and types for the triangle area and normal block.
`timescale 1ns / 1ps
package tan_pkg;

    localparam int AREA_WIDTH = 36;
    localparam int NXY_WIDTH  = 16;
    localparam int NZ_WIDTH   = 15;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_WIDTH  = $clog2(FIFO_DEPTH);
    localparam int CNT_WIDTH  = $clog2(FIFO_DEPTH + 1);

    localparam logic [AREA_WIDTH-1:0] AREA_MAX = '1;

    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [CNT_WIDTH-1:0] count;
    } fifo_stat_t;

endpackage

[rtl/core/tan_if.sv]
// Channel interfaces: triangle in, area and normal out.
`timescale 1ns / 1ps
interface tan_tri_if #(parameter int COORD_WIDTH = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] third_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        output ready
    );
endinterface

interface tan_res_if ();
    logic                                   valid;
    logic                                   ready;
    logic        [tan_pkg::AREA_WIDTH-1:0]  area;
    logic signed [tan_pkg::NXY_WIDTH-1:0]   unit_nx;
    logic signed [tan_pkg::NXY_WIDTH-1:0]   unit_ny;
    logic        [tan_pkg::NZ_WIDTH-1:0]    unit_nz;
    logic                                   degenerate;

    modport source (
        output valid, area, unit_nx, unit_ny, unit_nz, degenerate,
        input  ready
    );
    modport sink (
        input  valid, area, unit_nx, unit_ny, unit_nz, degenerate,
        output ready
    );
endinterface

[rtl/core/triangle_area_and_normal.sv]
// Top level: triangle area and upward unit normal.
// Takes one triangle and returns one result per cycle once the pipe is full, barring stalls.
// The front end (edges and cross product, 3 stages) feeds an 8-entry queue, and
// the back end pulls from it: squares (3 stages), a square root that yields one
// root bit per stage (2*COORD_WIDTH + NORMAL_FRAC_BITS + 5 stages), a divide that
// yields one quotient bit per stage in three lanes (NORMAL_FRAC_BITS + 2 stages),
// plus setup and output stages. A held output stalls only the back end; the front
// end keeps taking triangles until the queue holds no room for them.
`timescale 1ns / 1ps
`include "triangle_area_and_normal_defines.svh"
module triangle_area_and_normal #(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic      clk,
    input  logic      rst_n,
    tan_tri_if.sink   triangle,
    tan_res_if.source result
);
    import tan_pkg::*;

    localparam int MW = 2 * COORD_WIDTH + 2;
    localparam int IW = 3 * MW + 3;

    logic signed [COORD_WIDTH-1:0] vtx [9];
    logic                          push;
    logic [IW-1:0]                 push_data;
    logic [1:0]                    occ;
    logic                          pop;
    logic [IW-1:0]                 rd_data;
    fifo_stat_t                    stat;

    assign vtx[0] = triangle.first_x;
    assign vtx[1] = triangle.first_y;
    assign vtx[2] = triangle.first_z;
    assign vtx[3] = triangle.second_x;
    assign vtx[4] = triangle.second_y;
    assign vtx[5] = triangle.second_z;
    assign vtx[6] = triangle.third_x;
    assign vtx[7] = triangle.third_y;
    assign vtx[8] = triangle.third_z;

    // room is reserved for everything already inside the front end
    assign triangle.ready = ((CNT_WIDTH+1)'(occ) + (CNT_WIDTH+1)'(stat.count))
                          < (CNT_WIDTH+1)'(FIFO_DEPTH);

    tan_front #(
        .CW (COORD_WIDTH),
        .MW (MW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (triangle.valid && triangle.ready),
        .vtx       (vtx),
        .push      (push),
        .push_data (push_data),
        .occ       (occ)
    );

    tan_fifo #(
        .WIDTH (IW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .rd_data   (rd_data),
        .stat      (stat)
    );

    tan_back #(
        .MW (MW),
        .F  (NORMAL_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (!stat.empty),
        .in_data    (rd_data),
        .pop        (pop),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .area       (result.area),
        .unit_nx    (result.unit_nx),
        .unit_ny    (result.unit_ny),
        .unit_nz    (result.unit_nz),
        .degenerate (result.degenerate)
    );

    `TAN_ASSERT_IMPLY(a_no_push_when_full, push, !stat.full, "queue overflow")
    `TAN_ASSERT_NEXT(a_count_up, push && !pop, stat.count == $past(stat.count) + 1, "queue count")
    `TAN_ASSERT_IMPLY(a_degenerate_zero, result.valid && result.degenerate, result.area == '0 && result.unit_nx == '0 && result.unit_ny == '0 && result.unit_nz == '0, "degenerate result not zero")
    `TAN_ASSERT_IMPLY(a_area_nonzero, result.valid && !result.degenerate, result.area != '0, "zero area on live triangle")

endmodule

[rtl/core/tan_front.sv]
// Front end: edge vectors and cross product, three pipeline stages.
`timescale 1ns / 1ps
module tan_front #(
    parameter int CW = 16,
    parameter int MW = 2 * CW + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] vtx [9],
    output logic                 push,
    output logic [3*MW+2:0]      push_data,
    output logic [1:0]           occ
);
    import tan_pkg::*;

    logic [2:0]               vld_reg;
    logic signed [CW:0]       dif_reg [6];
    logic signed [2*CW+1:0]   prd_reg [6];
    logic [3*MW+2:0]          item_reg;
    logic signed [2*CW+2:0]   crs [3];
    logic [2:0]               cneg;
    logic [2:0][MW-1:0]       cmag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // u = first - second, v = first - third
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dif_reg[i]     <= (CW+1)'(vtx[i]) - (CW+1)'(vtx[3+i]);
            dif_reg[3 + i] <= (CW+1)'(vtx[i]) - (CW+1)'(vtx[6+i]);
        end
    end

    always_ff @(posedge clk)
    begin
        prd_reg[0] <= dif_reg[1] * dif_reg[5];
        prd_reg[1] <= dif_reg[2] * dif_reg[4];
        prd_reg[2] <= dif_reg[2] * dif_reg[3];
        prd_reg[3] <= dif_reg[0] * dif_reg[5];
        prd_reg[4] <= dif_reg[0] * dif_reg[4];
        prd_reg[5] <= dif_reg[1] * dif_reg[3];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            crs[i]  = (2*CW+3)'(prd_reg[2*i]) - (2*CW+3)'(prd_reg[2*i+1]);
            cneg[i] = crs[i][2*CW+2];
            cmag[i] = cneg[i] ? MW'(-crs[i]) : MW'(crs[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= {cneg, cmag};
    end

    assign push      = vld_reg[2];
    assign push_data = item_reg;
    assign occ       = 2'(vld_reg[0]) + 2'(vld_reg[1]) + 2'(vld_reg[2]);

endmodule

[rtl/core/tan_fifo.sv]
// Small queue between front and back ends, show-ahead read.
`timescale 1ns / 1ps
module tan_fifo #(
    parameter int WIDTH = 105
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    rd_data,
    output tan_pkg::fifo_stat_t stat
);
    import tan_pkg::*;

    logic [WIDTH-1:0]     mem [FIFO_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg;
    logic [PTR_WIDTH-1:0] rd_ptr_reg;
    logic [CNT_WIDTH-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_WIDTH'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_WIDTH'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_WIDTH'(1);
                2'b01:   count_reg <= count_reg - CNT_WIDTH'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign rd_data    = mem[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_WIDTH'(FIFO_DEPTH));

endmodule

[rtl/core/tan_back.sv]
// Back end: squared length, pipelined square root, per-lane divide, rounding.
`timescale 1ns / 1ps
module tan_back #(
    parameter int MW = 34,
    parameter int F  = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [3*MW+2:0]                    in_data,
    output logic                               pop,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic        [tan_pkg::AREA_WIDTH-1:0] area,
    output logic signed [tan_pkg::NXY_WIDTH-1:0]  unit_nx,
    output logic signed [tan_pkg::NXY_WIDTH-1:0]  unit_ny,
    output logic        [tan_pkg::NZ_WIDTH-1:0]   unit_nz,
    output logic                               degenerate
);
    import tan_pkg::*;

    localparam int K   = MW / 2;
    localparam int QW  = 2 * MW + 2;
    localparam int SW  = MW + 1;
    localparam int G   = F + 2;
    localparam int SN  = SW + G;
    localparam int LW  = SN;
    localparam int QB  = F + 2;
    localparam int XW  = MW + F + G + 4;
    localparam int NST = 3 + SN + 1 + QB + 1;
    localparam int OW  = (QB > NXY_WIDTH) ? QB : NXY_WIDTH;
    localparam int AXW = (SW + 1 > AREA_WIDTH) ? SW + 1 : AREA_WIDTH;
    localparam logic [QB-1:0] UNIT = {2'b01, {F{1'b0}}};

    typedef struct packed {
        logic               deg;
        logic [2:0]         neg;
        logic [2:0][MW-1:0] mag;
    } pay_t;

    logic            en;
    logic [NST-1:0]  vld_reg;
    pay_t            in_pay;
    pay_t            pay_reg [NST-1];

    logic [MW-1:0]   hh_reg [3];
    logic [MW-1:0]   hl_reg [3];
    logic [MW-1:0]   ll_reg [3];
    logic [2*MW-1:0] sq_reg [3];
    logic [QW-1:0]   q_reg;

    logic [LW-1:0]   rt_reg  [SN];
    logic [LW+1:0]   rm_reg  [SN];
    logic [QW-1:0]   qs_reg  [SN];
    logic [LW-1:0]   rt_next [SN];
    logic [LW+1:0]   rm_next [SN];
    logic [QW-1:0]   qs_next [SN];

    logic [XW-1:0]   dr_reg [QB+1][3];
    logic [QB-1:0]   dq_reg [QB+1][3];
    logic [LW-1:0]   ld_reg [QB+1];
    logic [XW-1:0]   dcmp   [QB];

    pay_t            fin;
    logic [SW:0]     lsum;
    logic [AXW-1:0]  aext;
    logic [QB-1:0]   msat [3];
    logic [OW-1:0]   sv   [3];

    logic [AREA_WIDTH-1:0] area_reg;
    logic [NXY_WIDTH-1:0]  nx_reg;
    logic [NXY_WIDTH-1:0]  ny_reg;
    logic [NZ_WIDTH-1:0]   nz_reg;
    logic                  deg_reg;

    // whole back end moves together; it holds only when the output is stuck
    assign en  = !vld_reg[NST-1] || out_ready;
    assign pop = en && in_valid;

    assign in_pay.deg = ~|in_data[3*MW-1:0];
    assign in_pay.neg = in_data[3*MW+2:3*MW];
    assign in_pay.mag = in_data[3*MW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0] <= in_pay;
            for (int i = 1; i < NST - 1; i++)
            begin
                pay_reg[i] <= pay_reg[i-1];
            end
        end
    end

    // squares from half-width partial products: c^2 = hh<<2K + 2hl<<K + ll
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                hh_reg[c] <= in_pay.mag[c][MW-1:K] * in_pay.mag[c][MW-1:K];
                hl_reg[c] <= in_pay.mag[c][MW-1:K] * in_pay.mag[c][K-1:0];
                ll_reg[c] <= in_pay.mag[c][K-1:0]  * in_pay.mag[c][K-1:0];
                sq_reg[c] <= ((2*MW)'(hh_reg[c]) << (2*K))
                           + ((2*MW)'(hl_reg[c]) << (K+1))
                           + (2*MW)'(ll_reg[c]);
            end
            q_reg <= QW'(sq_reg[0]) + QW'(sq_reg[1]) + QW'(sq_reg[2]);
        end
    end

    // digit-by-digit root of Q * 4^G, one root bit per stage;
    // the top SW bits of the root are isqrt(Q)
    for (genvar k = 0; k < SN; k++)
    begin : g_sqrt
        logic [LW-1:0] rt_in;
        logic [LW+1:0] rm_in;
        logic [QW-1:0] qs_in;
        logic [LW+1:0] rsh;
        logic [LW+1:0] trial;

        if (k == 0)
        begin : g_first
            assign rt_in = '0;
            assign rm_in = '0;
            assign qs_in = q_reg;
        end
        else
        begin : g_rest
            assign rt_in = rt_reg[k-1];
            assign rm_in = rm_reg[k-1];
            assign qs_in = qs_reg[k-1];
        end

        assign rsh        = {rm_in[LW-1:0], qs_in[QW-1 -: 2]};
        assign trial      = {rt_in, 2'b01};
        assign rm_next[k] = (rsh >= trial) ? rsh - trial : rsh;
        assign rt_next[k] = {rt_in[LW-2:0], rsh >= trial};
        assign qs_next[k] = qs_in << 2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SN; k++)
            begin
                rt_reg[k] <= rt_next[k];
                rm_reg[k] <= rm_next[k];
                qs_reg[k] <= qs_next[k];
            end
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    always_comb
    begin
        for (int j = 0; j < QB; j++)
        begin
            dcmp[j] = XW'(ld_reg[j]) << (QB - j);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ld_reg[0] <= rt_reg[SN-1];
            for (int c = 0; c < 3; c++)
            begin
                dr_reg[0][c] <= (XW'(pay_reg[2+SN].mag[c]) << (F+G+1))
                              + XW'(rt_reg[SN-1]);
                dq_reg[0][c] <= '0;
            end
            for (int j = 0; j < QB; j++)
            begin
                ld_reg[j+1] <= ld_reg[j];
                for (int c = 0; c < 3; c++)
                begin
                    dr_reg[j+1][c] <= (dr_reg[j][c] >= dcmp[j])
                                    ? dr_reg[j][c] - dcmp[j] : dr_reg[j][c];
                    dq_reg[j+1][c] <= {dq_reg[j][c][QB-2:0], dr_reg[j][c] >= dcmp[j]};
                end
            end
        end
    end

    assign fin  = pay_reg[NST-2];
    assign lsum = (SW+1)'(ld_reg[QB][LW-1:G]) + (SW+1)'(1);
    assign aext = AXW'(lsum >> 1);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            msat[c] = (dq_reg[QB][c] > UNIT) ? UNIT : dq_reg[QB][c];
            sv[c]   = OW'(msat[c]);
            if ((fin.neg[c] != fin.neg[2]) && (msat[c] != '0))
            begin
                sv[c] = -sv[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_reg <= fin.deg;
            if (fin.deg)
            begin
                area_reg <= '0;
                nx_reg   <= '0;
                ny_reg   <= '0;
                nz_reg   <= '0;
            end
            else
            begin
                area_reg <= (aext > AXW'(AREA_MAX)) ? AREA_MAX : aext[AREA_WIDTH-1:0];
                nx_reg   <= sv[0][NXY_WIDTH-1:0];
                ny_reg   <= sv[1][NXY_WIDTH-1:0];
                nz_reg   <= sv[2][NZ_WIDTH-1:0];
            end
        end
    end

    assign out_valid  = vld_reg[NST-1];
    assign area       = area_reg;
    assign unit_nx    = nx_reg;
    assign unit_ny    = ny_reg;
    assign unit_nz    = nz_reg;
    assign degenerate = deg_reg;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the triangle area and upward unit normal block.
`timescale 1ns / 1ps
module testbench;
    import tan_pkg::*;

    localparam int CW        = 16;
    localparam int FRAC      = 14;
    localparam int LATENCY   = 2 * CW + 2 * FRAC + 16;
    localparam int N_RANDOM  = 550;
    localparam int CYCLE_MAX = 400000;
    localparam int MAX_GAP   = 17;

    typedef struct packed {
        logic signed [CW-1:0] fx, fy, fz, sx, sy, sz, tx, ty, tz;
    } tri_t;

    typedef struct packed {
        logic [AREA_WIDTH-1:0] area;
        logic [NXY_WIDTH-1:0]  nx;
        logic [NXY_WIDTH-1:0]  ny;
        logic [NZ_WIDTH-1:0]   nz;
        logic                  degen;
    } normal_t;

    typedef struct packed {
        tri_t    t;
        logic    typed;
        normal_t e;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count = 0;
    int   cycle_count = 0;

    normal_t normal_expect_q[$];
    row_t    directed_q[$];

    tan_tri_if #(.COORD_WIDTH(CW)) tri_ch ();
    tan_res_if                     res_ch ();

    triangle_area_and_normal #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FRAC)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .triangle (tri_ch),
        .result   (res_ch)
    );

    always #5 clk = ~clk;

    function automatic logic [127:0] isqrt128(input logic [127:0] a);
        logic [127:0] rem, root, bitv;
        rem  = a;
        root = '0;
        bitv = 128'd1 << 126;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic normal_t predict_normal(input tri_t t);
        longint       ux, uy, uz, vx, vy, vz;
        longint       c[3];
        logic [127:0] m[3];
        logic [127:0] q, root, l, num, den, part;
        logic         neg[3];
        logic         flip;
        normal_t      r;
        ux = longint'(t.fx) - longint'(t.sx);
        uy = longint'(t.fy) - longint'(t.sy);
        uz = longint'(t.fz) - longint'(t.sz);
        vx = longint'(t.fx) - longint'(t.tx);
        vy = longint'(t.fy) - longint'(t.ty);
        vz = longint'(t.fz) - longint'(t.tz);
        c[0] = uy * vz - uz * vy;
        c[1] = uz * vx - ux * vz;
        c[2] = ux * vy - uy * vx;
        q = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = c[i] < 0;
            m[i]   = 128'(neg[i] ? -c[i] : c[i]);
            q      = q + m[i] * m[i];
        end
        r = '0;
        if (q == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        root   = (isqrt128(q) + 1) >> 1;
        r.area = (root > 128'(AREA_MAX)) ? AREA_MAX : root[AREA_WIDTH-1:0];
        // L ~ |C| * 2^(FRAC+2); each part is |Ci|/|C| rounded to nearest
        l    = isqrt128(q << (2 * (FRAC + 2)));
        den  = l << 1;
        flip = neg[2];
        for (int i = 0; i < 3; i++)
        begin
            num  = (m[i] << (2 * FRAC + 3)) + l;
            part = num / den;
            if (part > (128'd1 << FRAC))
                part = 128'd1 << FRAC;
            if ((neg[i] != flip) && part != 0)
                part = -part;
            if (i == 0) r.nx = part[NXY_WIDTH-1:0];
            if (i == 1) r.ny = part[NXY_WIDTH-1:0];
            if (i == 2) r.nz = part[NZ_WIDTH-1:0];
        end
        return r;
    endfunction

    task automatic add_row(input int fx, fy, fz, sx, sy, sz, tx, ty, tz,
                           input bit typed, input longint area,
                           input int nx, ny, nz, input bit degen);
        row_t r;
        r.t     = {16'(fx), 16'(fy), 16'(fz), 16'(sx), 16'(sy), 16'(sz),
                   16'(tx), 16'(ty), 16'(tz)};
        r.typed = typed;
        r.e     = {36'(area), 16'(nx), 16'(ny), 15'(nz), degen};
        directed_q = {directed_q, r};
    endtask

    function automatic logic [CW-1:0] rand_coord(input int kind);
        int pick;
        case (kind)
            1: return CW'($urandom_range(4095)) - CW'(2048);
            4:
            begin
                pick = $urandom_range(3);
                return (pick == 0) ? 16'sh8000 : (pick == 1) ? 16'sh7fff :
                       (pick == 2) ? 16'sh0000 : 16'shffff;
            end
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic tri_t rand_tri();
        int   kind;
        tri_t t;
        kind = $urandom_range(5);
        t = {rand_coord(kind), rand_coord(kind), rand_coord(kind),
             rand_coord(kind), rand_coord(kind), rand_coord(kind),
             rand_coord(kind), rand_coord(kind), rand_coord(kind)};
        if (kind == 2)
        begin
            // repeated vertex: zero-area triangle
            t.tx = t.fx; t.ty = t.fy; t.tz = t.fz;
        end
        else if (kind == 3)
        begin
            t.sz = t.fz; t.tz = t.fz;
        end
        else if (kind == 5)
        begin
            // third vertex on the line through the first two
            t.fx = t.fx >>> 2; t.fy = t.fy >>> 2; t.fz = t.fz >>> 2;
            t.sx = t.sx >>> 2; t.sy = t.sy >>> 2; t.sz = t.sz >>> 2;
            t.tx = CW'(2 * t.sx - t.fx);
            t.ty = CW'(2 * t.sy - t.fy);
            t.tz = CW'(2 * t.sz - t.fz);
        end
        return t;
    endfunction

    task automatic send_triangle(input tri_t t, input normal_t e);
        int gap;
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(MAX_GAP);
        if (gap > 0)
        begin
            tri_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tri_ch.valid    <= 1'b1;
        tri_ch.first_x  <= t.fx; tri_ch.first_y  <= t.fy; tri_ch.first_z  <= t.fz;
        tri_ch.second_x <= t.sx; tri_ch.second_y <= t.sy; tri_ch.second_z <= t.sz;
        tri_ch.third_x  <= t.tx; tri_ch.third_y  <= t.ty; tri_ch.third_z  <= t.tz;
        do
            @(posedge clk);
        while (!tri_ch.ready);
        normal_expect_q = {normal_expect_q, e};
    endtask

    // result side: random hold-off per transfer
    initial
    begin
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(3) == 0 ? 0 : $urandom_range(MAX_GAP);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        normal_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (normal_expect_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                e = normal_expect_q.pop_front();
                if (res_ch.area !== e.area)
                begin
                    $error("area: expected %0d, got %0d", e.area, res_ch.area);
                    fail_count++;
                end
                if (res_ch.unit_nx !== e.nx)
                begin
                    $error("unit_nx: expected %0d, got %0d", $signed(e.nx), res_ch.unit_nx);
                    fail_count++;
                end
                if (res_ch.unit_ny !== e.ny)
                begin
                    $error("unit_ny: expected %0d, got %0d", $signed(e.ny), res_ch.unit_ny);
                    fail_count++;
                end
                if (res_ch.unit_nz !== e.nz)
                begin
                    $error("unit_nz: expected %0d, got %0d", e.nz, res_ch.unit_nz);
                    fail_count++;
                end
                if (res_ch.degenerate !== e.degen)
                begin
                    $error("degenerate: expected %0d, got %0d", e.degen, res_ch.degenerate);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        tri_t t;
        tri_ch.valid    <= 1'b0;
        tri_ch.first_x  <= '0; tri_ch.first_y  <= '0; tri_ch.first_z  <= '0;
        tri_ch.second_x <= '0; tri_ch.second_y <= '0; tri_ch.second_z <= '0;
        tri_ch.third_x  <= '0; tri_ch.third_y  <= '0; tri_ch.third_z  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all vertices at the origin, then coincident at the extremes
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                1, 0, 0, 0, 0, 1);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                1, 0, 0, 0, 0, 1);
        // right triangle with legs of 256 in the xy plane, then with vertex order swapped (flip)
        add_row(0, 0, 0, -256, 0, 0, 0, -256, 0, 1, 32768, 0, 0, 16384, 0);
        add_row(0, 0, 0, 0, -256, 0, -256, 0, 0, 1, 32768, 0, 0, 16384, 0);
        // collinear vertices
        add_row(0, 0, 0, 100, 200, 300, 200, 400, 600, 1, 0, 0, 0, 0, 1);
        // triangles in the other axis planes
        add_row(0, 0, 0, 0, -256, 0, 0, 0, -256, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, -256, 0, -256, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, -256, 0, 0, 0, 0, -256, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, -256, -256, 0, 0, 0, 0, 0, 0, 0, 0);
        // largest edges
        add_row(32767, 32767, 32767, -32768, -32768, 32767, -32768, 32767, -32768,
                0, 0, 0, 0, 0, 0);
        add_row(-32768, 32767, -32768, 32767, -32768, -32768, 32767, 32767, 32767,
                0, 0, 0, 0, 0, 0);
        add_row(32767, -32768, 0, -32768, 32767, 0, -32768, -32768, 0, 0, 0, 0, 0, 0, 0);
        add_row(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767,
                0, 0, 0, 0, 0, 0);
        // tiny triangles, one lsb edges
        add_row(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(-1, -1, -1, 0, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0);
        add_row(5, 7, 3, 4, 7, 4, 5, 6, 2, 0, 0, 0, 0, 0, 0);
        // a skewed normal with small components, then a general-position triangle
        add_row(0, 0, 0, 12000, 1, 0, 1, 12000, 1, 0, 0, 0, 0, 0, 0);
        add_row(100, -200, 300, -400, 500, -600, 700, -800, 900, 0, 0, 0, 0, 0, 0);

        foreach (directed_q[i])
            send_triangle(directed_q[i].t,
                          directed_q[i].typed ? directed_q[i].e : predict_normal(directed_q[i].t));

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
            begin
                // drain the pipe completely once mid-run
                tri_ch.valid <= 1'b0;
                while (normal_expect_q.size() != 0)
                    @(posedge clk);
            end
            t = rand_tri();
            send_triangle(t, predict_normal(t));
        end
        tri_ch.valid <= 1'b0;

        while (normal_expect_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[triangle_area_and_normal.f]
+incdir+rtl/core
rtl/core/tan_pkg.sv
rtl/core/tan_if.sv
rtl/core/tan_front.sv
rtl/core/tan_fifo.sv
rtl/core/tan_back.sv
rtl/core/triangle_area_and_normal.sv
sim/testbench.sv
